// ===== sv/dtluq_pkg.sv =====
// ----------------------------------------------------------------------------
// dtluq_pkg
// Shared types, sizes and helpers for the dedup two-level update queue.
// ----------------------------------------------------------------------------
package dtluq_pkg;

  // Depth of each FIFO; pointers wrap modulo this value.
  localparam int NUM_ITEMS = 1024;
  localparam int PTR_W     = $clog2(NUM_ITEMS);
  localparam int CNT_W     = PTR_W + 1;

  // Item index field width, fixed by the stream format.
  localparam int IDX_W     = 10;

  // Membership bitmap is stored as rows of ROW_BITS flags.
  localparam int ROW_BITS  = 32;
  localparam int ROW_SEL_W = $clog2(ROW_BITS);
  localparam int MAP_ITEMS = (NUM_ITEMS < (1 << IDX_W)) ? NUM_ITEMS : (1 << IDX_W);
  localparam int MAP_ROWS  = (MAP_ITEMS + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_A_W   = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
  localparam int ROW_DEPTH = 1 << ROW_A_W;

  typedef enum logic [2:0] {
    CMD_CLEAR   = 3'd0,
    CMD_ENQUEUE = 3'd1,
    CMD_PEEK    = 3'd2,
    CMD_DEPRIO  = 3'd3,
    CMD_DEQUEUE = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  // Advance a FIFO pointer with wrap at the last entry.
  function automatic logic [PTR_W-1:0] ptr_wrap(input logic [PTR_W-1:0] ptr);
    ptr_wrap = (ptr == PTR_W'(NUM_ITEMS - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

endpackage

// ===== sv/dedup_two_level_update_queue_core.sv =====
// ----------------------------------------------------------------------------
// dedup_two_level_update_queue_core
// Deduplicating update queue: membership bitmap plus a primary and a
// deferred FIFO of item indices, all held in synchronous RAMs.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake               Content
//  -------  ---  ----------------------  ------------------------------------
//  s_axis   in   tvalid/tready           tuser: cmd; tdata: item_index,
//                                        icon_empty
//  m_axis   out  tvalid/tready           tdata: head_valid, head_index,
//                                        primary_was_busy, status
//
//  Each command has an accept cycle, which issues reads of the bitmap row
//  and of the entry behind each FIFO head, and an execute cycle, which
//  modifies and writes back, then loads the result register.
//  Reset is synchronous; it empties both FIFOs and marks every bitmap row
//  unwritten, so no clearing pass is needed. The clear command does the same.
//  Execute waits while the result register is still full and not taken; the
//  RAM read data holds meanwhile.
// ----------------------------------------------------------------------------
module dedup_two_level_update_queue_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [9:0] item_index, [10] icon_empty
  input  logic [2:0]  s_axis_tuser,   // [2:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [0] head_valid, [10:1] head_index,
                                      // [11] primary_was_busy, [13:12] status
);

  localparam int PTR_W     = dtluq_pkg::PTR_W;
  localparam int CNT_W     = dtluq_pkg::CNT_W;
  localparam int IDX_W     = dtluq_pkg::IDX_W;
  localparam int ROW_BITS  = dtluq_pkg::ROW_BITS;
  localparam int ROW_SEL_W = dtluq_pkg::ROW_SEL_W;
  localparam int ROW_A_W   = dtluq_pkg::ROW_A_W;
  localparam int ROW_DEPTH = dtluq_pkg::ROW_DEPTH;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  // Latched command.
  dtluq_pkg::cmd_t    cmd;
  logic [IDX_W-1:0]   idx;
  logic               icon;

  // FIFO control and cached heads.
  logic [PTR_W-1:0]   p_rd, p_wr, d_rd, d_wr;
  logic [CNT_W-1:0]   p_count, d_count;
  logic [IDX_W-1:0]   p_head, d_head;
  logic [ROW_DEPTH-1:0] row_valid;

  // Result register.
  logic                  out_valid;
  logic                  out_head_valid;
  logic [IDX_W-1:0]      out_head_index;
  logic                  out_busy;
  dtluq_pkg::status_t    out_status;

  // RAM ports.
  logic                  accept;
  logic [ROW_A_W-1:0]    map_raddr, map_waddr;
  logic [ROW_BITS-1:0]   map_rdata, map_wdata;
  logic                  map_we;
  logic [IDX_W-1:0]      pmem_rdata, dmem_rdata, dmem_wdata;
  logic                  pmem_we, dmem_we;

  // Execute-cycle decisions.
  logic                  fire;
  logic                  in_range;
  logic [ROW_BITS-1:0]   row_cur;
  logic                  is_member;
  logic                  p_push, p_pop, d_push, d_pop;
  logic                  map_set, map_clr;
  logic                  busy;
  dtluq_pkg::status_t    status;
  logic [CNT_W-1:0]      p_count_next, d_count_next;
  logic [IDX_W-1:0]      p_head_next, d_head_next;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign fire          = (state == S_EXEC) && (!out_valid || m_axis_tready);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_status, out_busy, out_head_index, out_head_valid};

  // Bitmap row addressed by the incoming index on accept, by the latched one later.
  assign map_raddr = ROW_A_W'(s_axis_tdata[IDX_W-1:0] >> ROW_SEL_W);
  assign map_waddr = ROW_A_W'(idx >> ROW_SEL_W);

  dtluq_ram #(.WIDTH(ROW_BITS), .DEPTH(ROW_DEPTH)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (accept),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // Prefetch the entry behind each head: it becomes the head on a pop.
  dtluq_ram #(.WIDTH(IDX_W), .DEPTH(dtluq_pkg::NUM_ITEMS)) u_primary_ram (
    .clk   (clk),
    .we    (pmem_we),
    .waddr (p_wr),
    .wdata (idx),
    .re    (accept),
    .raddr (dtluq_pkg::ptr_wrap(p_rd)),
    .rdata (pmem_rdata)
  );

  dtluq_ram #(.WIDTH(IDX_W), .DEPTH(dtluq_pkg::NUM_ITEMS)) u_deferred_ram (
    .clk   (clk),
    .we    (dmem_we),
    .waddr (d_wr),
    .wdata (dmem_wdata),
    .re    (accept),
    .raddr (dtluq_pkg::ptr_wrap(d_rd)),
    .rdata (dmem_rdata)
  );

  always_comb begin
    in_range  = (32'(idx) < dtluq_pkg::NUM_ITEMS);
    // An unwritten row reads as all clear.
    row_cur   = row_valid[map_waddr] ? map_rdata : '0;
    is_member = row_cur[idx[ROW_SEL_W-1:0]];

    p_push  = 1'b0;
    p_pop   = 1'b0;
    d_push  = 1'b0;
    d_pop   = 1'b0;
    map_set = 1'b0;
    map_clr = 1'b0;
    busy    = 1'b0;
    status  = dtluq_pkg::ST_OK;

    unique case (cmd)
      dtluq_pkg::CMD_ENQUEUE: begin
        if (in_range && !is_member) begin
          if (p_count == CNT_W'(dtluq_pkg::NUM_ITEMS)) begin
            status = dtluq_pkg::ST_PUSH_FULL;
          end else begin
            p_push  = 1'b1;
            map_set = 1'b1;
          end
        end
      end
      dtluq_pkg::CMD_DEPRIO: begin
        if (p_count != '0) begin
          busy = 1'b1;
          if (icon) begin
            // Move the primary head over to the deferred FIFO.
            if (d_count == CNT_W'(dtluq_pkg::NUM_ITEMS)) begin
              status = dtluq_pkg::ST_PUSH_FULL;
            end else begin
              p_pop  = 1'b1;
              d_push = 1'b1;
            end
          end else begin
            p_pop   = 1'b1;
            map_clr = in_range;
          end
        end
      end
      dtluq_pkg::CMD_DEQUEUE: begin
        if (p_count != '0) begin
          p_pop = 1'b1;
        end else if (d_count != '0) begin
          d_pop = 1'b1;
        end else begin
          status = dtluq_pkg::ST_POP_EMPTY;
        end
        map_clr = in_range;
      end
      default: begin
        // Clear, peek and unknown codes touch no FIFO entry here.
      end
    endcase

    map_we     = fire && (map_set || map_clr);
    map_wdata  = row_cur;
    map_wdata[idx[ROW_SEL_W-1:0]] = map_set;
    pmem_we    = fire && p_push;
    dmem_we    = fire && d_push;
    dmem_wdata = p_head;

    if (cmd == dtluq_pkg::CMD_CLEAR) begin
      p_count_next = '0;
      d_count_next = '0;
    end else begin
      p_count_next = p_count + CNT_W'(p_push) - CNT_W'(p_pop);
      d_count_next = d_count + CNT_W'(d_push) - CNT_W'(d_pop);
    end

    priority if (p_pop) begin
      p_head_next = pmem_rdata;
    end else if (p_push && p_count == '0) begin
      p_head_next = idx;
    end else begin
      p_head_next = p_head;
    end

    priority if (d_pop) begin
      d_head_next = dmem_rdata;
    end else if (d_push && d_count == '0) begin
      d_head_next = p_head;
    end else begin
      d_head_next = d_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      p_rd      <= '0;
      p_wr      <= '0;
      d_rd      <= '0;
      d_wr      <= '0;
      p_count   <= '0;
      d_count   <= '0;
      row_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one loads in its place.
      if (m_axis_tready && !fire) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd   <= dtluq_pkg::cmd_t'(s_axis_tuser);
            idx   <= s_axis_tdata[IDX_W-1:0];
            icon  <= s_axis_tdata[IDX_W];
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            state   <= S_IDLE;
            p_count <= p_count_next;
            d_count <= d_count_next;
            p_head  <= p_head_next;
            d_head  <= d_head_next;
            if (cmd == dtluq_pkg::CMD_CLEAR) begin
              p_rd      <= '0;
              p_wr      <= '0;
              d_rd      <= '0;
              d_wr      <= '0;
              row_valid <= '0;
            end else begin
              if (p_push) p_wr <= dtluq_pkg::ptr_wrap(p_wr);
              if (p_pop)  p_rd <= dtluq_pkg::ptr_wrap(p_rd);
              if (d_push) d_wr <= dtluq_pkg::ptr_wrap(d_wr);
              if (d_pop)  d_rd <= dtluq_pkg::ptr_wrap(d_rd);
              if (map_we) row_valid[map_waddr] <= 1'b1;
            end
            // Report the head after the step, primary first.
            out_valid      <= 1'b1;
            out_head_valid <= (p_count_next != '0) || (d_count_next != '0);
            out_head_index <= (p_count_next != '0) ? p_head_next :
                              (d_count_next != '0) ? d_head_next : '0;
            out_busy       <= busy;
            out_status     <= status;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // One command at a time: accept is always followed by a busy cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_axis_tready)
    else $error("input accepted while a command was executing");

  // Occupancy never exceeds the FIFO depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (p_count <= CNT_W'(dtluq_pkg::NUM_ITEMS)) && (d_count <= CNT_W'(dtluq_pkg::NUM_ITEMS)))
    else $error("FIFO count above depth");

  // An empty FIFO has its pointers together.
  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    ((p_count == '0) |-> (p_rd == p_wr)) and ((d_count == '0) |-> (d_rd == d_wr)))
    else $error("empty FIFO with pointers apart");

  // A pop from empty leaves both FIFOs empty.
  a_pop_empty_no_head: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == dtluq_pkg::ST_POP_EMPTY) |-> !out_head_valid)
    else $error("head reported after pop from empty");

endmodule

// ===== sv/dtluq_ram.sv =====
// ----------------------------------------------------------------------------
// dtluq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dtluq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
